/* hdl/pcm_pkg.sv */
package pcm_pkg;

  localparam int MAX_PARTS_DEF  = 16;
  localparam int COUNT_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int OUT_W      = 32;

  localparam logic [CFG_IDX_W-1:0] REG_METRIC_SELECT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_PARTS     = 1'd1;

  localparam logic [1:0] MODE_VERTEX = 2'd0;
  localparam logic [1:0] MODE_ADJ    = 2'd1;
  localparam logic [1:0] MODE_EVAL   = 2'd2;

  localparam logic [1:0] MET_CUT    = 2'd0;
  localparam logic [1:0] MET_SPARSE = 2'd1;
  localparam logic [1:0] MET_COND   = 2'd2;
  localparam logic [1:0] MET_NCUT   = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  part_u;
    logic [3:0]  part_v;
    logic [15:0] degree;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] metric_value;
    logic             zero_divisor;
    logic             saturated;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_EV_RD,
    ST_EV_GOT,
    ST_DIV,
    ST_DIV_END,
    ST_EV_FIN
  } state_t;

endpackage

/* hdl/partition_cut_metric_engine.sv */
// partition cut metric engine
// in channel (in_valid/in_ready/in_data) carries vertex, adjacency and evaluate items.
// a record that changes a counter row goes through an accumulate state, in_ready low
// there (read-modify-write of the counter memories); other records stay idle.
// an evaluate item runs a restoring divider, one quotient bit per cycle, producing
// COUNT_BITS+FRAC_BITS quotient bits per division; the steps per metric are:
//   cut size: no division
//   sparse cut, conductance: rows 0 and 1, one division unless the divisor is zero
//   normalized cut: a division per partition, none from a zero volume on
// when it ends the result goes to the out register (out_valid/out_ready/out_data)
// and all counters are cleared at once through per-row valid bits.
// a stalled receiver holds the result; records keep being accepted meanwhile,
// and the next evaluate item waits in its last step until the out register is free.
// cfg_we writes metric_select (index 0) or num_parts (index 1); the user writes
// idle only, unenforced by the block. rst (synchronous) clears counters, the out
// register and sets metric_select 0, num_parts 2; ready in the cycle after reset.
module partition_cut_metric_engine import pcm_pkg::*; #(
  parameter int MAX_PARTS  = MAX_PARTS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PW   = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int CW   = $clog2(MAX_PARTS + 1);
  localparam int CB   = COUNT_BITS;
  localparam int QW   = COUNT_BITS + FRAC_BITS;
  localparam int CNTW = $clog2(QW);

  state_t state, state_next;

  logic [1:0]            metric_select;
  logic [CFG_DATA_W-1:0] num_parts;

  logic [CB-1:0] cut_mem [MAX_PARTS];
  logic [CB-1:0] vc_mem  [MAX_PARTS];
  logic [CB-1:0] vol_mem [MAX_PARTS];
  logic [MAX_PARTS-1:0] row_vld;

  logic [CB-1:0] rd_cut, rd_vc, rd_vol;
  logic          rd_vld;
  logic [PW-1:0] rd_addr, in_idx, addr;

  logic          is_vertex;
  logic [15:0]   degree;
  logic          overflow_seen;

  logic [CB-1:0]   held, num;
  logic [QW-1:0]   dq;
  logic [CB-1:0]   rem, dvs;
  logic [CNTW-1:0] cnt;
  logic [OUT_W-1:0] acc;
  logic            zdiv, sat_r;

  logic in_fire, counted, mem_we, fin_load, div_start, last;
  logic [CW-1:0] np;

  logic [CB-1:0] cut_v, vc_v, vol_v, sel_v, min_v, div_n, div_d;
  logic [CB:0]   cut_sum, vc_sum, vol_sum;
  logic [CB:0]   t, diff;
  logic          ge;
  logic [QW+OUT_W-1:0] q_ext;
  logic          term_sat;
  logic [OUT_W-1:0] term;
  logic [OUT_W:0]   acc_sum;

  assign in_fire = in_valid && in_ready;
  assign in_idx  = PW'(in_data.part_u);
  assign counted = (32'(in_data.part_u) < MAX_PARTS) &&
                   ((in_data.mode == MODE_VERTEX) ||
                    ((in_data.mode == MODE_ADJ) && (in_data.part_u != in_data.part_v)));

  always_comb begin
    if (num_parts < CFG_DATA_W'(2)) begin
      np = CW'(2);
    end else if (32'(num_parts) > MAX_PARTS) begin
      np = CW'(MAX_PARTS);
    end else begin
      np = CW'(num_parts);
    end
  end
  assign last = (CW'(addr) + CW'(1)) == np;

  assign cut_v = rd_vld ? rd_cut : '0;
  assign vc_v  = rd_vld ? rd_vc  : '0;
  assign vol_v = rd_vld ? rd_vol : '0;
  assign sel_v = (metric_select == MET_SPARSE) ? vc_v : vol_v;
  assign min_v = (held < sel_v) ? held : sel_v;

  assign cut_sum = {1'b0, cut_v} + (CB+1)'(1);
  assign vc_sum  = {1'b0, vc_v} + (CB+1)'(1);
  assign vol_sum = {1'b0, vol_v} + (CB+1)'(degree);

  assign t    = {rem, dq[QW-1]};
  assign ge   = t >= {1'b0, dvs};
  assign diff = t - {1'b0, dvs};

  assign q_ext    = (QW+OUT_W)'(dq);
  assign term_sat = |q_ext[QW+OUT_W-1:OUT_W];
  assign term     = term_sat ? '1 : q_ext[OUT_W-1:0];
  assign acc_sum  = {1'b0, acc} + {1'b0, term};

  always_comb begin
    unique case (metric_select) inside
      MET_CUT: begin
        div_n = cut_v;
        div_d = CB'(1);
      end
      MET_SPARSE, MET_COND: begin
        div_n = num;
        div_d = min_v;
      end
      default: begin
        div_n = cut_v;
        div_d = vol_v;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data.mode == MODE_EVAL) begin
            state_next = ST_EV_RD;
          end else if (counted) begin
            state_next = ST_ACC;
          end
        end
      end
      ST_ACC:   state_next = ST_IDLE;
      ST_EV_RD: state_next = ST_EV_GOT;
      ST_EV_GOT: begin
        unique case (metric_select) inside
          MET_CUT: state_next = ST_DIV_END;
          MET_SPARSE, MET_COND: begin
            if (addr == '0) begin
              state_next = ST_EV_RD;
            end else if (min_v == '0) begin
              state_next = ST_EV_FIN;
            end else begin
              state_next = ST_DIV;
            end
          end
          default: begin
            if ((vol_v == '0) || zdiv) begin
              state_next = last ? ST_EV_FIN : ST_EV_RD;
            end else begin
              state_next = ST_DIV;
            end
          end
        endcase
      end
      ST_DIV: begin
        if (cnt == '0) begin
          state_next = ST_DIV_END;
        end
      end
      ST_DIV_END: begin
        state_next = ((metric_select == MET_NCUT) && !last) ? ST_EV_RD : ST_EV_FIN;
      end
      ST_EV_FIN: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = state == ST_IDLE;
    mem_we    = state == ST_ACC;
    fin_load  = (state == ST_EV_FIN) && (!out_valid || out_ready);
    div_start = (state == ST_EV_GOT) &&
                ((state_next == ST_DIV) || (state_next == ST_DIV_END));
    rd_addr   = (state == ST_IDLE) ? in_idx : addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      metric_select <= MET_CUT;
      num_parts     <= CFG_DATA_W'(2);
      row_vld       <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_METRIC_SELECT: metric_select <= cfg_data[1:0];
          REG_NUM_PARTS:     num_parts <= cfg_data;
          default: ;
        endcase
      end
      if (mem_we) begin
        row_vld[addr] <= 1'b1;
        if (is_vertex) begin
          if (vc_sum[CB] || vol_sum[CB]) begin
            overflow_seen <= 1'b1;
          end
        end else if (cut_sum[CB]) begin
          overflow_seen <= 1'b1;
        end
      end
      if (fin_load) begin
        row_vld       <= '0;
        overflow_seen <= 1'b0;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // counter memories
  always_ff @(posedge clk) begin
    if (mem_we) begin
      if (is_vertex) begin
        cut_mem[addr] <= cut_v;
        vc_mem[addr]  <= vc_sum[CB] ? '1 : vc_sum[CB-1:0];
        vol_mem[addr] <= vol_sum[CB] ? '1 : vol_sum[CB-1:0];
      end else begin
        cut_mem[addr] <= cut_sum[CB] ? '1 : cut_sum[CB-1:0];
        vc_mem[addr]  <= vc_v;
        vol_mem[addr] <= vol_v;
      end
    end
    rd_cut <= cut_mem[rd_addr];
    rd_vc  <= vc_mem[rd_addr];
    rd_vol <= vol_mem[rd_addr];
    rd_vld <= row_vld[rd_addr];
  end

  // datapath
  always_ff @(posedge clk) begin
    if (div_start) begin
      dq  <= {div_n, FRAC_BITS'(0)};
      rem <= '0;
      dvs <= div_d;
      cnt <= CNTW'(QW - 1);
    end
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          is_vertex <= in_data.mode == MODE_VERTEX;
          degree    <= in_data.degree;
          if (in_data.mode == MODE_EVAL) begin
            addr  <= '0;
            acc   <= '0;
            zdiv  <= 1'b0;
            sat_r <= 1'b0;
          end else begin
            addr <= in_idx;
          end
        end
      end
      ST_EV_GOT: begin
        unique case (metric_select) inside
          MET_CUT: ;
          MET_SPARSE, MET_COND: begin
            if (addr == '0) begin
              held <= sel_v;
              num  <= cut_v;
              addr <= PW'(1);
            end else if (min_v == '0) begin
              zdiv <= 1'b1;
            end
          end
          default: begin
            if (vol_v == '0) begin
              zdiv <= 1'b1;
            end
            if (((vol_v == '0) || zdiv) && !last) begin
              addr <= addr + PW'(1);
            end
          end
        endcase
      end
      ST_DIV: begin
        rem <= ge ? diff[CB-1:0] : t[CB-1:0];
        dq  <= {dq[QW-2:0], ge};
        cnt <= cnt - CNTW'(1);
      end
      ST_DIV_END: begin
        acc <= acc_sum[OUT_W] ? '1 : acc_sum[OUT_W-1:0];
        if (acc_sum[OUT_W] || term_sat) begin
          sat_r <= 1'b1;
        end
        if ((metric_select == MET_NCUT) && !last) begin
          addr <= addr + PW'(1);
        end
      end
      default: ;
    endcase
    if (fin_load) begin
      out_data.metric_value <= zdiv ? '0 : acc;
      out_data.zero_divisor <= zdiv;
      out_data.saturated    <= (sat_r && !zdiv) || overflow_seen;
    end
  end

endmodule

/* sim/partition_cut_metric_engine_tb.sv */
module partition_cut_metric_engine_tb import pcm_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 300;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predicted counters and registers
  logic [31:0] cut_edges [16];
  logic [31:0] vert_count [16];
  logic [31:0] vol_sum [16];
  bit          cnt_overflow;
  logic [1:0]  sel_metric;
  logic [4:0]  parts_reg;

  out_item_t pending_metrics[$];
  int        fail_count = 0;
  int        idle_cycles = 0;
  int        send_gap_max = 18;
  int        recv_gap_max = 18;
  int        ready_wait = 0;
  int        hold_left = 0;

  partition_cut_metric_engine u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [32:0] sat_count(input logic [31:0] cnt, input logic [31:0] inc);
    logic [32:0] s;
    s = {1'b0, cnt} + {1'b0, inc};
    if (s[32]) begin
      s = {1'b1, 32'hFFFF_FFFF};
    end
    return s;
  endfunction

  // bit 32 flags a saturated quotient
  function automatic logic [32:0] fixed_quotient(input logic [31:0] num, input logic [31:0] den);
    logic [63:0] whole;
    logic [63:0] rem;
    logic [63:0] frac;
    whole = {32'd0, num} / {32'd0, den};
    rem   = {32'd0, num} % {32'd0, den};
    if (whole > 64'hFFFF) begin
      return {1'b1, 32'hFFFF_FFFF};
    end
    frac = (rem << 16) / {32'd0, den};
    return {1'b0, whole[15:0], frac[15:0]};
  endfunction

  task automatic clear_counts();
    for (int i = 0; i < 16; i++) begin
      cut_edges[i] = '0;
      vert_count[i] = '0;
      vol_sum[i] = '0;
    end
    cnt_overflow = 1'b0;
  endtask

  task automatic account_item(input in_item_t it);
    logic [32:0] s;
    logic [32:0] q;
    logic [32:0] acc;
    logic [31:0] den;
    bit          sat;
    bit          zdiv;
    int          np;
    out_item_t   res;
    case (it.mode)
      MODE_VERTEX: begin
        s = sat_count(vert_count[it.part_u], 32'd1);
        cnt_overflow |= s[32];
        vert_count[it.part_u] = s[31:0];
        s = sat_count(vol_sum[it.part_u], {16'd0, it.degree});
        cnt_overflow |= s[32];
        vol_sum[it.part_u] = s[31:0];
      end
      MODE_ADJ: begin
        if (it.part_u != it.part_v) begin
          s = sat_count(cut_edges[it.part_u], 32'd1);
          cnt_overflow |= s[32];
          cut_edges[it.part_u] = s[31:0];
        end
      end
      MODE_EVAL: begin
        sat = 1'b0;
        zdiv = 1'b0;
        acc = '0;
        case (sel_metric)
          MET_CUT: begin
            q = fixed_quotient(cut_edges[0], 32'd1);
            acc = {1'b0, q[31:0]};
            sat = q[32];
          end
          MET_SPARSE, MET_COND: begin
            if (sel_metric == MET_SPARSE) begin
              den = (vert_count[0] < vert_count[1]) ? vert_count[0] : vert_count[1];
            end else begin
              den = (vol_sum[0] < vol_sum[1]) ? vol_sum[0] : vol_sum[1];
            end
            if (den == 0) begin
              zdiv = 1'b1;
            end else begin
              q = fixed_quotient(cut_edges[0], den);
              acc = {1'b0, q[31:0]};
              sat = q[32];
            end
          end
          default: begin
            np = (parts_reg < 2) ? 2 : ((parts_reg > 16) ? 16 : int'(parts_reg));
            for (int i = 0; i < np; i++) begin
              if (vol_sum[i] == 0) begin
                zdiv = 1'b1;
              end
            end
            if (!zdiv) begin
              for (int i = 0; i < np; i++) begin
                q = fixed_quotient(cut_edges[i], vol_sum[i]);
                sat |= q[32];
                acc = acc + {1'b0, q[31:0]};
                if (acc[32]) begin
                  acc = {1'b0, 32'hFFFF_FFFF};
                  sat = 1'b1;
                end
              end
            end
          end
        endcase
        if (zdiv) begin
          acc = '0;
          sat = 1'b0;
        end
        res.metric_value = acc[31:0];
        res.zero_divisor = zdiv;
        res.saturated = sat | cnt_overflow;
        pending_metrics.push_back(res);
        clear_counts();
      end
      default: ;
    endcase
  endtask

  function automatic in_item_t make_item(input logic [1:0] mode, input logic [3:0] pu,
                                         input logic [3:0] pv, input logic [15:0] deg);
    in_item_t it;
    it.mode = mode;
    it.part_u = pu;
    it.part_v = pv;
    it.degree = deg;
    return it;
  endfunction

  function automatic logic [15:0] rand_degree();
    return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
  endfunction

  // entered and left at a falling edge
  task automatic send_item(input in_item_t it);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    account_item(it);
    @(negedge clk);
  endtask

  task automatic send_vertex(input logic [3:0] pu, input logic [15:0] deg);
    send_item(make_item(MODE_VERTEX, pu, 4'($urandom), deg));
  endtask

  task automatic send_adj(input logic [3:0] pu, input logic [3:0] pv);
    send_item(make_item(MODE_ADJ, pu, pv, 16'($urandom)));
  endtask

  task automatic send_eval();
    send_item(make_item(MODE_EVAL, 4'($urandom), 4'($urandom), 16'($urandom)));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_metrics.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // block must be idle
  task automatic write_setting(input logic [1:0] sel, input logic [4:0] parts);
    logic [2:0] junk;
    junk = 3'($urandom);
    cfg_we <= 1'b1;
    cfg_index <= REG_METRIC_SELECT;
    cfg_data <= {junk, sel};
    @(negedge clk);
    cfg_index <= REG_NUM_PARTS;
    cfg_data <= parts;
    @(negedge clk);
    cfg_we <= 1'b0;
    sel_metric = sel;
    parts_reg = parts;
  endtask

  // one graph: a vertex for most partitions, random records, then evaluate
  task automatic send_graph_sequence(input int used_parts, input int num_records);
    int          r;
    logic [3:0]  pu;
    logic [3:0]  pv;
    for (int p = 0; p < used_parts; p++) begin
      if ($urandom_range(0, 9) != 0) begin
        send_vertex(4'(p), rand_degree());
      end
    end
    for (int k = 0; k < num_records; k++) begin
      r = $urandom_range(0, 19);
      pu = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, used_parts - 1));
      pv = ($urandom_range(0, 2) == 0) ? pu : 4'($urandom_range(0, used_parts));
      if ($urandom_range(0, 7) == 0) begin
        pv = 4'($urandom);
      end
      if (r < 8) begin
        send_vertex(pu, rand_degree());
      end else if (r < 18) begin
        send_adj(pu, pv);
      end else if (r == 18) begin
        send_item(make_item(2'd3, pu, pv, 16'($urandom)));
      end else begin
        send_eval();
      end
    end
    send_eval();
  endtask

  task automatic test_cut_size();
    send_eval();
    send_vertex(4'd0, 16'd0);
    send_vertex(4'd15, 16'hFFFF);
    send_adj(4'd0, 4'd0);
    send_adj(4'd0, 4'd1);
    send_adj(4'd0, 4'd15);
    send_adj(4'd15, 4'd0);
    send_item(make_item(2'd3, 4'hF, 4'hF, 16'hFFFF));
    send_eval();
    drain_results();
  endtask

  task automatic test_zero_divisors();
    write_setting(MET_SPARSE, 5'd0);
    send_vertex(4'd0, 16'd5);
    send_eval();
    drain_results();
    write_setting(MET_COND, 5'd2);
    send_vertex(4'd0, 16'd0);
    send_vertex(4'd1, 16'd0);
    send_adj(4'd0, 4'd1);
    send_eval();
    send_vertex(4'd0, 16'd3);
    send_vertex(4'd1, 16'd7);
    send_adj(4'd0, 4'd1);
    send_adj(4'd0, 4'd2);
    send_eval();
    drain_results();
    write_setting(MET_NCUT, 5'd31);
    send_vertex(4'd0, 16'd1);
    send_eval();
    drain_results();
    write_setting(MET_NCUT, 5'd0);
    send_vertex(4'd0, 16'd1);
    send_vertex(4'd1, 16'hFFFF);
    send_adj(4'd0, 4'd1);
    send_adj(4'd1, 4'd0);
    send_adj(4'd1, 4'd1);
    send_eval();
    drain_results();
  endtask

  task automatic test_random_metrics();
    logic [1:0] sel;
    logic [4:0] parts;
    int         used;
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin sel = MET_CUT;    parts = 5'd2;  end
        1: begin sel = MET_SPARSE; parts = 5'd16; end
        2: begin sel = MET_COND;   parts = 5'd0;  end
        3: begin sel = MET_NCUT;   parts = 5'd2;  end
        4: begin sel = MET_NCUT;   parts = 5'd16; end
        5: begin sel = MET_NCUT;   parts = 5'd31; end
        6: begin sel = MET_NCUT;   parts = 5'd1;  end
        7: begin sel = MET_SPARSE; parts = 5'd17; end
        default: begin
          sel = 2'($urandom_range(0, 3));
          parts = ($urandom_range(0, 5) == 0) ? 5'($urandom) : 5'($urandom_range(2, 5));
        end
      endcase
      // no idling on every third phase
      send_gap_max = (ph % 3 == 1) ? 0 : 18;
      recv_gap_max = (ph % 3 == 1) ? 0 : 18;
      write_setting(sel, parts);
      for (int s = 0; s < 3; s++) begin
        if (sel == MET_NCUT) begin
          used = (parts < 2) ? 2 : ((parts > 16) ? 16 : int'(parts));
        end else begin
          used = $urandom_range(2, 3);
        end
        send_graph_sequence(used, $urandom_range(4, 14));
      end
      drain_results();
    end
    send_gap_max = 18;
    recv_gap_max = 18;
  endtask

  task automatic test_output_stall();
    write_setting(MET_SPARSE, 5'd2);
    send_gap_max = 0;
    hold_left = LONG_HOLD;
    send_graph_sequence(2, 10);
    send_graph_sequence(2, 10);
    send_graph_sequence(3, 20);
    drain_results();
    send_gap_max = 18;
    send_graph_sequence(2, 12);
    drain_results();
  endtask

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (ready_wait > 0) begin
      out_ready <= 1'b0;
      ready_wait--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result check
  always @(posedge clk) begin
    out_item_t exp_res;
    if (!rst && out_valid && out_ready) begin
      ready_wait = $urandom_range(0, recv_gap_max);
      if (pending_metrics.size() == 0) begin
        $display("%0t: unexpected item, actual %h", $time, out_data);
        fail_count++;
      end else begin
        exp_res = pending_metrics.pop_front();
        if (out_data.metric_value !== exp_res.metric_value) begin
          $display("%0t: metric_value expected %h actual %h", $time,
                   exp_res.metric_value, out_data.metric_value);
          fail_count++;
        end
        if (out_data.zero_divisor !== exp_res.zero_divisor) begin
          $display("%0t: zero_divisor expected %b actual %b", $time,
                   exp_res.zero_divisor, out_data.zero_divisor);
          fail_count++;
        end
        if (out_data.saturated !== exp_res.saturated) begin
          $display("%0t: saturated expected %b actual %b", $time,
                   exp_res.saturated, out_data.saturated);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    ready_wait = $urandom_range(0, recv_gap_max);
    clear_counts();
    sel_metric = MET_CUT;
    parts_reg = 5'd2;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_cut_size();
    test_zero_divisors();
    test_random_metrics();
    test_output_stall();
    drain_results();
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/pcm_pkg.sv
hdl/partition_cut_metric_engine.sv
sim/partition_cut_metric_engine_tb.sv
